// ===== design/drying_thermostat_controller_defines.svh =====
// Assertion macros for the drying thermostat controller.
// Included by the top level; no other dependencies.
`ifndef DRYING_THERMOSTAT_CONTROLLER_DEFINES_SVH
`define DRYING_THERMOSTAT_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define DTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtc_pkg.sv =====
// Shared types, constants and setpoint step function for the drying
// thermostat controller. No dependencies.
package dtc_pkg;

  localparam int TEMP_W     = 11;
  localparam int WEIGHT_W   = 24;
  localparam int POINT_W    = 7;
  localparam int TICK_W     = 16;
  localparam int PCT_W      = 7;
  localparam int LIMIT_W    = PCT_W + WEIGHT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [TICK_W-1:0]   DEBOUNCE_RST = 16'd200;
  localparam logic [PCT_W-1:0]    LOSS_PCT_RST = 7'd70;
  localparam logic [POINT_W-1:0]  HIGH_LIM_RST = 7'd80;
  localparam logic [POINT_W-1:0]  LOW_LIM_RST  = 7'd10;
  localparam logic [WEIGHT_W-1:0] INIT_WT_RST  = 24'd0;
  localparam logic [POINT_W-1:0]  UPPER_RST    = 7'd45;
  localparam logic [POINT_W-1:0]  LOWER_RST    = 7'd35;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_LOSS_PCT   = 3'd1,
    REG_HIGH_LIMIT = 3'd2,
    REG_LOW_LIMIT  = 3'd3,
    REG_INIT_WT    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_tenths;
    logic                     temperature_valid;
    logic [WEIGHT_W-1:0]      weight_now;
    logic                     set_pressed;
    logic                     up_pressed;
    logic                     down_pressed;
  } sample_t;

  typedef struct packed {
    logic               fan_on;
    logic               heater_on;
    logic               settings_active;
    logic               editing_high;
    logic               edit_selected;
    logic [POINT_W-1:0] high_setpoint;
    logic [POINT_W-1:0] low_setpoint;
    logic               dried;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0]   debounce_ticks;
    logic [POINT_W-1:0]  high_limit;
    logic [POINT_W-1:0]  low_limit;
    logic [WEIGHT_W-1:0] initial_weight;
    logic [LIMIT_W-1:0]  dry_limit;
  } cfg_t;

  typedef struct packed {
    logic [POINT_W-1:0] upper;
    logic [POINT_W-1:0] lower;
  } points_t;

  function automatic logic [POINT_W-1:0] sat7(input logic signed [POINT_W+1:0] v);
    logic [POINT_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({2'b00, {POINT_W{1'b1}}})) r = '1;
    else r = v[POINT_W-1:0];
    return r;
  endfunction

  // one degree step of the selected setpoint, with its clamp
  function automatic points_t step_points(input points_t p, input logic high_sel,
                                          input logic up, input logic [POINT_W-1:0] hl,
                                          input logic [POINT_W-1:0] ll);
    logic signed [POINT_W+1:0] hi;
    logic signed [POINT_W+1:0] lo;
    logic signed [POINT_W+1:0] v;
    points_t r;
    r  = p;
    hi = $signed({2'b00, p.upper});
    lo = $signed({2'b00, p.lower});
    if (high_sel) begin
      if (up) begin
        v = hi + 9'sd1;
        if (v > $signed({2'b00, hl})) v = $signed({2'b00, hl});
      end else begin
        v = hi - 9'sd1;
        if (v <= lo) v = lo + 9'sd1;
      end
      r.upper = sat7(v);
    end else begin
      if (up) begin
        v = lo + 9'sd1;
        if (v >= hi) v = hi - 9'sd1;
      end else begin
        v = lo - 9'sd1;
        if (v < $signed({2'b00, ll})) v = $signed({2'b00, ll});
      end
      r.lower = sat7(v);
    end
    return r;
  endfunction

endpackage

// ===== design/drying_thermostat_controller.sv =====
// Drying thermostat controller top level: sample register, result register
// and handshakes. Depends on dtc_pkg, dtc_cfg, dtc_ctrl and the defines header.
//
//  channel  handshake              payload
//  sample   sample_valid/stall     sample (sample_t), one tick request
//  result   result_valid/stall     result (result_t), one per request
//  config   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request per cycle sustained while result_stall is low; result_valid rises
// after the sample register and the state update into the result register.
// Synchronous reset restores the default registers and the thermostat state.
// A stalled result holds the sample register; sample_stall rises only when both
// registers are full and result_stall is high.
`include "drying_thermostat_controller_defines.svh"

module drying_thermostat_controller
  import dtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  sample_t in_q;
  logic    in_full;
  logic    advance;
  logic    accept;
  result_t res_next;

  dtc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dtc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_q),
    .cfg  (cfg),
    .res  (res_next)
  );

  assign advance      = in_full && (!result_valid || !result_stall);
  assign sample_stall = in_full && !advance;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) in_full <= 1'b0;
    else if (accept) in_full <= 1'b1;
    else if (advance) in_full <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) in_q <= sample;
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (advance) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance) result <= res_next;
  end

  `DTC_ASSERT_NOW(a_stall_only_when_blocked, clk, rst, sample_stall,
                  in_full && result_valid && result_stall, "sample stalled without cause")
  `DTC_ASSERT_NEXT(a_advance_gives_result, clk, rst, advance, result_valid,
                   "advanced request produced no result")
  `DTC_ASSERT_NOW(a_fan_heater_exclusive, clk, rst, result_valid,
                  !(result.fan_on && result.heater_on), "fan and heater both on")

endmodule

// ===== design/dtc_cfg.sv =====
// Configuration register file and the dry threshold product.
// Depends on dtc_pkg.
module dtc_cfg
  import dtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [TICK_W-1:0]   debounce_ticks;
  logic [PCT_W-1:0]    dry_loss_percent;
  logic [POINT_W-1:0]  high_limit;
  logic [POINT_W-1:0]  low_limit;
  logic [WEIGHT_W-1:0] initial_weight;
  logic [LIMIT_W-1:0]  dry_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RST;
      dry_loss_percent <= LOSS_PCT_RST;
      high_limit       <= HIGH_LIM_RST;
      low_limit        <= LOW_LIM_RST;
      initial_weight   <= INIT_WT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_DEBOUNCE:   debounce_ticks   <= cfg_data[TICK_W-1:0];
        REG_LOSS_PCT:   dry_loss_percent <= cfg_data[PCT_W-1:0];
        REG_HIGH_LIMIT: high_limit       <= cfg_data[POINT_W-1:0];
        REG_LOW_LIMIT:  low_limit        <= cfg_data[POINT_W-1:0];
        REG_INIT_WT:    initial_weight   <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // percent * initial weight
  assign dry_limit = {{WEIGHT_W{1'b0}}, dry_loss_percent} * {{PCT_W{1'b0}}, initial_weight};

  assign cfg.debounce_ticks = debounce_ticks;
  assign cfg.high_limit     = high_limit;
  assign cfg.low_limit      = low_limit;
  assign cfg.initial_weight = initial_weight;
  assign cfg.dry_limit      = dry_limit;

endmodule

// ===== design/dtc_ctrl.sv =====
// Thermostat state registers and per-tick update: debounce, settings
// editing, fan/heater control and dry latch. Depends on dtc_pkg.
module dtc_ctrl
  import dtc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  sample_t item,
  input  cfg_t    cfg,
  output result_t res
);

  logic               settings_mode, settings_mode_next;
  logic               selection_made, selection_made_next;
  logic               high_selected, high_selected_next;
  points_t            points, points_next;
  logic [TICK_W-1:0]  ticks_since_press, ticks_since_press_next;
  logic               dry_latch, dry_latch_next;
  logic               fan_drive, fan_drive_next;
  logic               heater_drive, heater_drive_next;

  logic                      pressed;
  logic signed [TEMP_W+1:0]  temp_ext;
  logic signed [TEMP_W+1:0]  upper_x10;
  logic signed [TEMP_W+1:0]  lower_x10;
  logic signed [WEIGHT_W+1:0] diff;
  logic signed [LIMIT_W+1:0] loss;

  always_comb begin
    settings_mode_next  = settings_mode;
    selection_made_next = selection_made;
    high_selected_next  = high_selected;
    points_next         = points;
    dry_latch_next      = dry_latch;
    fan_drive_next      = fan_drive;
    heater_drive_next   = heater_drive;
    pressed             = 1'b0;

    if (ticks_since_press >= cfg.debounce_ticks) begin
      if (item.set_pressed) begin
        pressed             = 1'b1;
        settings_mode_next  = !settings_mode;
        selection_made_next = 1'b0;
      end
      if (settings_mode_next) begin
        if (!selection_made_next) begin
          if (item.up_pressed) begin
            pressed             = 1'b1;
            high_selected_next  = 1'b1;
            selection_made_next = 1'b1;
          end
          if (item.down_pressed) begin
            pressed             = 1'b1;
            high_selected_next  = 1'b0;
            selection_made_next = 1'b1;
          end
        end else begin
          if (item.up_pressed) begin
            pressed     = 1'b1;
            points_next = step_points(points_next, high_selected_next, 1'b1,
                                      cfg.high_limit, cfg.low_limit);
          end
          if (item.down_pressed) begin
            pressed     = 1'b1;
            points_next = step_points(points_next, high_selected_next, 1'b0,
                                      cfg.high_limit, cfg.low_limit);
          end
        end
      end
    end

    if (pressed) ticks_since_press_next = {{(TICK_W-1){1'b0}}, 1'b1};
    else if (ticks_since_press != {TICK_W{1'b1}})
      ticks_since_press_next = ticks_since_press + {{(TICK_W-1){1'b0}}, 1'b1};
    else ticks_since_press_next = ticks_since_press;

    temp_ext  = {{2{item.temperature_tenths[TEMP_W-1]}}, item.temperature_tenths};
    upper_x10 = $signed({2'b00, {{(TEMP_W-POINT_W){1'b0}}, points_next.upper} * 11'd10});
    lower_x10 = $signed({2'b00, {{(TEMP_W-POINT_W){1'b0}}, points_next.lower} * 11'd10});
    diff = $signed({2'b00, cfg.initial_weight}) - $signed({2'b00, item.weight_now});
    loss = {{(LIMIT_W-WEIGHT_W){diff[WEIGHT_W+1]}}, diff} * 33'd100;

    if (!settings_mode_next && !dry_latch) begin
      fan_drive_next    = 1'b0;
      heater_drive_next = 1'b0;
      if (item.temperature_valid) begin
        if (temp_ext > upper_x10) fan_drive_next = 1'b1;
        else if (temp_ext < lower_x10) heater_drive_next = 1'b1;
      end
      if (cfg.initial_weight != '0 && loss > $signed({2'b00, cfg.dry_limit}))
        dry_latch_next = 1'b1;
    end

    res.fan_on          = fan_drive_next;
    res.heater_on       = heater_drive_next;
    res.settings_active = settings_mode_next;
    res.editing_high    = high_selected_next;
    res.edit_selected   = selection_made_next;
    res.high_setpoint   = points_next.upper;
    res.low_setpoint    = points_next.lower;
    res.dried           = dry_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settings_mode     <= 1'b0;
      selection_made    <= 1'b0;
      high_selected     <= 1'b1;
      points.upper      <= UPPER_RST;
      points.lower      <= LOWER_RST;
      ticks_since_press <= '0;
      dry_latch         <= 1'b0;
      fan_drive         <= 1'b0;
      heater_drive      <= 1'b0;
    end else if (fire) begin
      settings_mode     <= settings_mode_next;
      selection_made    <= selection_made_next;
      high_selected     <= high_selected_next;
      points            <= points_next;
      ticks_since_press <= ticks_since_press_next;
      dry_latch         <= dry_latch_next;
      fan_drive         <= fan_drive_next;
      heater_drive      <= heater_drive_next;
    end
  end

endmodule
